// ----- design/ftp_port_pasv_address_parser_core_defines.svh -----
// assertion macros for the ftp port/pasv address parser core
// used by the top level only, no other dependencies
`ifndef FTP_PORT_PASV_ADDRESS_PARSER_CORE_DEFINES_SVH
`define FTP_PORT_PASV_ADDRESS_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define FPP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpp check failed");
`define FPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpp check failed");
`else
`define FPP_ASSERT_SAME(label, clk, rst, ante, cons)
`define FPP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/fpp_pkg.sv -----
// shared types and constants for the ftp port/pasv address parser
// no dependencies
package fpp_pkg;

   localparam logic [15:0] MAX_NUMBER = 16'd65535;
   localparam int unsigned NUM_COUNT  = 6;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_COUNT = 2'd1;
   localparam logic [1:0] STATUS_PAREN = 2'd2;

   localparam logic MODE_PORT = 1'b0;
   localparam logic MODE_PASV = 1'b1;

   typedef enum logic [2:0] {
      TOK_DIGIT,
      TOK_COMMA,
      TOK_MINUS,
      TOK_OPEN,
      TOK_CLOSE,
      TOK_OTHER
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   digit;
      logic         opcode;
      logic         first;
      logic         last;
   } tok_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

// ----- design/fpp_if.sv -----
// valid/ready channel interfaces for the parser's word and result streams
// depends on nothing
interface fpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       opcode;
   logic       last_byte;

   modport source (output valid, output data_byte, output opcode, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input opcode, input last_byte,
                 output ready);
endinterface

interface fpp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [16:0] host_part_a;
   logic signed [16:0] host_part_b;
   logic signed [16:0] host_part_c;
   logic signed [16:0] host_part_d;
   logic [15:0]        port_number;

   modport source (output valid, output status, output host_part_a, output host_part_b,
                   output host_part_c, output host_part_d, output port_number,
                   input ready);
   modport sink (input valid, input status, input host_part_a, input host_part_b,
                 input host_part_c, input host_part_d, input port_number,
                 output ready);
endinterface

// ----- design/fpp_front.sv -----
// front end: accepts byte words, classifies them into tokens, marks line starts
// depends on fpp_pkg and fpp_req_if
module fpp_front
   import fpp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   fpp_req_if.sink        req,
   input  queue_stat_type q_stat,
   output logic           push,
   output tok_type        push_tok
);

   logic first_ff;
   logic first_in;
   logic [7:0] digit_wide;

   assign req.ready  = !q_stat.full;
   assign push       = req.valid && !q_stat.full;
   assign digit_wide = req.data_byte - CHAR_ZERO;

   always_comb begin
      first_in = first_ff;
      if (push) begin
         first_in = req.last_byte;
      end
   end

   always_comb begin
      push_tok.digit  = digit_wide[3:0];
      push_tok.opcode = req.opcode;
      push_tok.first  = first_ff;
      push_tok.last   = req.last_byte;
      if (req.data_byte >= CHAR_ZERO && req.data_byte <= CHAR_NINE) begin
         push_tok.kind = TOK_DIGIT;
      end else begin
         unique case (req.data_byte)
            CHAR_COMMA: push_tok.kind = TOK_COMMA;
            CHAR_MINUS: push_tok.kind = TOK_MINUS;
            CHAR_OPEN:  push_tok.kind = TOK_OPEN;
            CHAR_CLOSE: push_tok.kind = TOK_CLOSE;
            default:    push_tok.kind = TOK_OTHER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

endmodule

// ----- design/fpp_queue.sv -----
// two-entry token queue between the front and back ends
// depends on fpp_pkg
module fpp_queue
   import fpp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tok_type        push_tok,
   input  logic           pop,
   output tok_type        head_tok,
   output queue_stat_type q_stat
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   tok_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_tok     = entry_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

// ----- design/fpp_back.sv -----
// back end: number accumulation, parenthesis tracking and result register
// depends on fpp_pkg and fpp_rsp_if
module fpp_back
   import fpp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  tok_type        head_tok,
   input  queue_stat_type q_stat,
   output logic           pop,
   fpp_rsp_if.source      rsp
);

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_INSIDE,
      PH_CLOSED
   } phase_type;

   phase_type          phase_ff, phase_in, b_phase;
   logic               mode_ff, mode_in;
   logic               nonempty_ff, nonempty_in;
   logic [15:0]        acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               innum_ff, innum_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic signed [16:0] store_ff [NUM_COUNT];
   logic signed [16:0] store_in [NUM_COUNT];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic signed [16:0] part_a_ff, part_a_in;
   logic signed [16:0] part_b_ff, part_b_in;
   logic signed [16:0] part_c_ff, part_c_in;
   logic signed [16:0] part_d_ff, part_d_in;
   logic [15:0]        port_ff, port_in;

   logic               out_free;
   logic               parse_en;
   logic               close_num;
   logic [19:0]        prod;
   logic signed [16:0] closed_val;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = !q_stat.empty && (!head_tok.last || out_free);

   always_comb begin
      // line start clears the per-line state and latches the mode
      mode_in     = head_tok.first ? head_tok.opcode : mode_ff;
      b_phase     = head_tok.first ? PH_SEARCH : phase_ff;
      phase_in    = b_phase;
      nonempty_in = head_tok.first ? 1'b0 : nonempty_ff;
      acc_in      = head_tok.first ? '0 : acc_ff;
      neg_in      = head_tok.first ? 1'b0 : neg_ff;
      innum_in    = head_tok.first ? 1'b0 : innum_ff;
      cnt_in      = head_tok.first ? '0 : cnt_ff;
      for (int i = 0; i < NUM_COUNT; i++) begin
         store_in[i] = store_ff[i];
      end

      parse_en  = (mode_in == MODE_PORT) ||
                  (b_phase == PH_INSIDE && head_tok.kind != TOK_CLOSE);
      close_num = (parse_en && head_tok.kind == TOK_COMMA) ||
                  (mode_in == MODE_PASV && b_phase == PH_INSIDE &&
                   head_tok.kind == TOK_CLOSE) ||
                  (mode_in == MODE_PORT && head_tok.last);

      if (mode_in == MODE_PASV) begin
         if (b_phase == PH_SEARCH && head_tok.kind == TOK_OPEN) begin
            phase_in = PH_INSIDE;
         end else if (b_phase == PH_INSIDE) begin
            if (head_tok.kind == TOK_CLOSE) begin
               phase_in = PH_CLOSED;
            end else begin
               nonempty_in = 1'b1;
            end
         end
      end

      // acc * 10 + digit, saturating
      prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + {16'd0, head_tok.digit};
      if (parse_en) begin
         case (head_tok.kind)
            TOK_DIGIT: begin
               acc_in   = (prod > {4'd0, MAX_NUMBER}) ? MAX_NUMBER : prod[15:0];
               innum_in = 1'b1;
            end
            TOK_MINUS: begin
               neg_in   = 1'b1;
               innum_in = 1'b1;
            end
            default: ;
         endcase
      end

      closed_val = neg_in ? -$signed({1'b0, acc_in}) : $signed({1'b0, acc_in});
      if (close_num) begin
         if (innum_in) begin
            if (cnt_in < 3'(NUM_COUNT)) begin
               store_in[cnt_in] = closed_val;
            end
            if (cnt_in != 3'd7) begin
               cnt_in = cnt_in + 3'd1;
            end
         end
         acc_in   = '0;
         innum_in = 1'b0;
         neg_in   = 1'b0;
      end

      if (mode_in == MODE_PASV && (phase_in != PH_CLOSED || !nonempty_in)) begin
         status_in = STATUS_PAREN;
      end else if (cnt_in != 3'(NUM_COUNT)) begin
         status_in = STATUS_COUNT;
      end else begin
         status_in = STATUS_OK;
      end

      if (status_in == STATUS_OK) begin
         part_a_in = store_in[0];
         part_b_in = store_in[1];
         part_c_in = store_in[2];
         part_d_in = store_in[3];
         port_in   = {store_in[4][7:0], store_in[5][7:0]};
      end else begin
         part_a_in = '0;
         part_b_in = '0;
         part_c_in = '0;
         part_d_in = '0;
         port_in   = '0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (pop && head_tok.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         mode_ff      <= MODE_PORT;
         nonempty_ff  <= 1'b0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         innum_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            mode_ff     <= mode_in;
            nonempty_ff <= nonempty_in;
            acc_ff      <= acc_in;
            neg_ff      <= neg_in;
            innum_ff    <= innum_in;
            cnt_ff      <= cnt_in;
         end
      end
      if (pop) begin
         for (int i = 0; i < NUM_COUNT; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
      if (pop && head_tok.last) begin
         status_ff <= status_in;
         part_a_ff <= part_a_in;
         part_b_ff <= part_b_in;
         part_c_ff <= part_c_in;
         part_d_ff <= part_d_in;
         port_ff   <= port_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.host_part_a = part_a_ff;
   assign rsp.host_part_b = part_b_ff;
   assign rsp.host_part_c = part_c_ff;
   assign rsp.host_part_d = part_d_ff;
   assign rsp.port_number = port_ff;

endmodule

// ----- design/ftp_port_pasv_address_parser_core.sv -----
// a line's last byte word goes through the queue entry, then the result register, to reach rsp
// throughput: one byte word per cycle while the queue has room; back end retires one token a cycle
// a line's final word waits in the queue only while an earlier result word is still held
// reset: synchronous, active high; clears queue, parse state and result valid
// the number store is not reset and is fully rewritten by every line that reports ok
`include "ftp_port_pasv_address_parser_core_defines.svh"

module ftp_port_pasv_address_parser_core
   import fpp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   fpp_req_if.sink   req_chan,
   fpp_rsp_if.source rsp_chan
);

   // front to queue
   logic           push;
   tok_type        push_tok;

   // queue to back
   logic           pop;
   tok_type        head_tok;
   queue_stat_type q_stat;

   // short names for the checks below
   logic           last_pop;
   logic           rsp_fail;
   logic           rsp_all_zero;

   // classify each byte word and flag the first word of a line
   fpp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_tok (push_tok)
   );

   // short token queue so the back end can stall on the result side alone
   fpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .pop      (pop),
      .head_tok (head_tok),
      .q_stat   (q_stat)
   );

   // number parsing, paren tracking and the result register
   fpp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_tok (head_tok),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   // a line's final token leaving the queue
   assign last_pop     = pop && head_tok.last;
   assign rsp_fail     = rsp_chan.valid && rsp_chan.status != STATUS_OK;
   assign rsp_all_zero = rsp_chan.host_part_a == '0 && rsp_chan.host_part_b == '0 &&
                         rsp_chan.host_part_c == '0 && rsp_chan.host_part_d == '0 &&
                         rsp_chan.port_number == '0;

   // the back end never retires a token from an empty queue
   `FPP_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, !q_stat.empty)
   // a new result word only follows the retirement of a line's final token
   `FPP_ASSERT_NEXT(a_rsp_from_last, clock, reset, !rsp_chan.valid && !last_pop, !rsp_chan.valid)
   // failed lines report all-zero address and port
   `FPP_ASSERT_SAME(a_fail_zero, clock, reset, rsp_fail, rsp_all_zero)

endmodule

// ----- sim/fpp_address_checker.sv -----
// checker for the ftp port/pasv address parser: watches both channels, predicts results
// depends on fpp_pkg and the fpp_req_if / fpp_rsp_if interfaces
module fpp_address_checker
   import fpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fpp_req_if          req_mon,
   fpp_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned waiting,
   output int unsigned results_seen
);

   typedef enum logic [1:0] {PH_SEARCH, PH_INSIDE, PH_CLOSED} paren_phase_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [16:0] host_a;
      logic signed [16:0] host_b;
      logic signed [16:0] host_c;
      logic signed [16:0] host_d;
      logic [15:0]        port;
   } address_word_type;

   address_word_type expected_q[$];
   address_word_type head;

   logic               mode;
   paren_phase_type    phase;
   logic               nonempty;
   logic [15:0]        accum;
   logic               neg;
   logic               in_num;
   logic [2:0]         count;
   logic signed [16:0] store [6];
   logic               first;

   initial begin
      fail_count   = 0;
      waiting      = 0;
      results_seen = 0;
   end

   task automatic clear_line();
      phase    = PH_SEARCH;
      nonempty = 1'b0;
      accum    = '0;
      neg      = 1'b0;
      in_num   = 1'b0;
      count    = '0;
   endtask

   task automatic end_number();
      logic signed [16:0] v;
      if (in_num) begin
         v = $signed({1'b0, accum});
         if (neg) v = -v;
         if (count < 6) store[count] = v;
         if (count < 7) count++;
      end
      accum  = '0;
      in_num = 1'b0;
      neg    = 1'b0;
   endtask

   task automatic take_char(input logic [7:0] c);
      int unsigned t;
      if (c == CHAR_COMMA) begin
         end_number();
      end else if (c == CHAR_MINUS) begin
         neg    = 1'b1;
         in_num = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         t = int'(accum) * 10 + int'(c - CHAR_ZERO);
         if (t > MAX_NUMBER) t = MAX_NUMBER;
         accum  = t[15:0];
         in_num = 1'b1;
      end
   endtask

   // expected result words wait here in order
   task automatic queue_expected(input address_word_type w);
      expected_q.insert(expected_q.size(), w);
   endtask

   // one byte word in; on the last byte the expected result word is queued
   task automatic predict_word(input logic [7:0] c, input logic op, input logic last);
      address_word_type w;
      if (first) begin
         mode  = op;
         clear_line();
         first = 1'b0;
      end
      if (mode == MODE_PORT) begin
         take_char(c);
      end else if (phase == PH_SEARCH) begin
         if (c == CHAR_OPEN) phase = PH_INSIDE;
      end else if (phase == PH_INSIDE) begin
         if (c == CHAR_CLOSE) begin
            end_number();
            phase = PH_CLOSED;
         end else begin
            nonempty = 1'b1;
            take_char(c);
         end
      end
      if (last) begin
         if (mode == MODE_PORT) end_number();
         w = '0;
         if (mode == MODE_PASV && (phase != PH_CLOSED || !nonempty)) begin
            w.status = STATUS_PAREN;
         end else if (count != 6) begin
            w.status = STATUS_COUNT;
         end else begin
            w.status = STATUS_OK;
            w.host_a = store[0];
            w.host_b = store[1];
            w.host_c = store[2];
            w.host_d = store[3];
            w.port   = {store[4][7:0], store[5][7:0]};
         end
         queue_expected(w);
         clear_line();
         first = 1'b1;
      end
   endtask

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (got !== want) begin
         if (fail_count < 10)
            $display("mismatch on %s at %0t: expected %0h, got %0h", name, $time, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         mode  = MODE_PORT;
         first = 1'b1;
         clear_line();
         waiting = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("result word at %0t with nothing expected", $time);
               fail_count++;
            end else begin
               head = expected_q.pop_front();
               check_field("status", head.status, rsp_mon.status);
               check_field("host_part_a", head.host_a, rsp_mon.host_part_a);
               check_field("host_part_b", head.host_b, rsp_mon.host_part_b);
               check_field("host_part_c", head.host_c, rsp_mon.host_part_c);
               check_field("host_part_d", head.host_d, rsp_mon.host_part_d);
               check_field("port_number", head.port, rsp_mon.port_number);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_word(req_mon.data_byte, req_mon.opcode, req_mon.last_byte);
         waiting = expected_q.size();
      end
   end

endmodule

// ----- sim/ftp_port_pasv_address_parser_core_test.sv -----
// top of the ftp port/pasv address parser test: clock, reset, byte word stimulus, result stalls
// depends on fpp_pkg, fpp_if.sv, the parser core and fpp_address_checker
module ftp_port_pasv_address_parser_core_test;
   import fpp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 250000;
   localparam int unsigned BYTE_BUDGET = 650;
   localparam int unsigned MIN_LINES   = 30;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam logic [7:0]  CHAR_SPACE  = 8'h20;

   logic clock;
   logic reset;

   fpp_req_if req_if ();
   fpp_rsp_if rsp_if ();

   int unsigned fail_count;
   int unsigned waiting;
   int unsigned results_seen;

   // idle rates in percent (per byte word sent, per cycle of ready), changed as the run goes on
   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;
   bit          hold_request;
   bit          hold_done;

   byte unsigned line_q[$];
   int unsigned  bytes_sent;
   int unsigned  port_lines;
   int unsigned  pasv_lines;

   ftp_port_pasv_address_parser_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   fpp_address_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .fail_count   (fail_count),
      .waiting      (waiting),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends up here
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            // long stretch with ready low so the core backs up into its input
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            hold_done    = 1'b1;
            rsp_if.ready = 1'b1;
         end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_if.ready = 1'b1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // one byte word; may open with an idle burst, returns at the falling edge after acceptance
   task automatic send_word(input logic [7:0] b, input logic op, input logic last);
      if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
         req_if.valid     = 1'b0;
         req_if.data_byte = 8'($urandom_range(0, 255));
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.data_byte = b;
      req_if.opcode    = op;
      req_if.last_byte = last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // adds one byte to the end of the line being built
   task automatic append_byte(input byte unsigned b);
      line_q.insert(line_q.size(), b);
   endtask

   // sends the built line; opcode only matters on the first byte, so the rest get noise
   task automatic send_line(input logic op);
      int   i;
      int   n;
      logic opc;
      if (line_q.size() == 0) append_byte(CHAR_SPACE);
      n = line_q.size();
      for (i = 0; i < n; i++) begin
         opc = 1'($urandom_range(0, 1));
         if (i == 0) opc = op;
         send_word(line_q[i], opc, i == n - 1);
      end
      if (op == MODE_PASV) pasv_lines++;
      else port_lines++;
      line_q.delete();
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   // filler that the parser ignores: mostly spaces, otherwise any non-token byte
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      if ($urandom_range(0, 1)) return CHAR_SPACE;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_COMMA || c == CHAR_MINUS || c == CHAR_OPEN || c == CHAR_CLOSE ||
             (c >= CHAR_ZERO && c <= CHAR_NINE));
      return c;
   endfunction

   // one number: mostly octets, some full 16-bit, some overflowing, some bare minus, some with leading zeros
   task automatic add_number();
      int unsigned kind;
      int          minus_at;
      int          i;
      bit          neg;
      string       ds;
      kind = $urandom_range(0, 99);
      neg  = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 6) == 0) append_byte(noise_char());
      if (kind < 70) begin
         ds = $sformatf("%0d", $urandom_range(0, 255));
      end else if (kind < 80) begin
         ds = $sformatf("%0d", $urandom_range(0, 65535));
      end else if (kind < 88) begin
         ds = "";
         repeat ($urandom_range(6, 10)) ds = {ds, $sformatf("%0d", $urandom_range(0, 9))};
      end else if (kind < 94) begin
         ds  = "";
         neg = 1'b1;
      end else begin
         ds = $sformatf("00%0d", $urandom_range(0, 99));
      end
      // the minus may sit before, inside or after the digits
      minus_at = $urandom_range(0, ds.len());
      for (i = 0; i <= ds.len(); i++) begin
         if (neg && i == minus_at) append_byte(CHAR_MINUS);
         if (i < ds.len()) append_byte(ds[i]);
      end
      if ($urandom_range(0, 6) == 0) append_byte(noise_char());
   endtask

   task automatic add_numbers(input int unsigned n);
      int unsigned k;
      for (k = 0; k < n; k++) begin
         add_number();
         if (k + 1 < n) append_byte(CHAR_COMMA);
      end
   endtask

   // reply line: junk prefix without '(', optional parens around the list, junk suffix
   task automatic build_pasv(input int unsigned n, input bit with_open, input bit with_close);
      logic [7:0] c;
      repeat ($urandom_range(0, 6)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_OPEN);
         append_byte(c);
      end
      if (with_open) append_byte(CHAR_OPEN);
      add_numbers(n);
      if (with_close) append_byte(CHAR_CLOSE);
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int unsigned kind;
      int unsigned line_no;
      int unsigned n;
      logic        op;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.opcode    = MODE_PORT;
      req_if.last_byte = 1'b0;
      tx_idle_pct      = 20;
      rx_idle_pct      = 20;
      hold_request     = 1'b0;
      hold_done        = 1'b0;
      bytes_sent       = 0;
      port_lines       = 0;
      pasv_lines       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed lines: plain ok, extremes and saturation
      add_text("1,2,3,4,5,6");                   send_line(MODE_PORT);
      add_text("-65535,65535,0,255,-1,999999");  send_line(MODE_PORT);
      // too many numbers, count saturating
      add_text("1,2,3,4,5,6,7");                 send_line(MODE_PORT);
      add_text("1,2,3,4,5,6,7,8,9");             send_line(MODE_PORT);
      // bare minus gives zero, trailing minus still negates
      add_text("1,2,-,4,5,6");                   send_line(MODE_PORT);
      add_text("(10,2-,3,4,5,6)");               send_line(MODE_PORT);
      // too few numbers, and a one-word line
      add_text("1,2,3");                         send_line(MODE_PORT);
      add_text("7");                             send_line(MODE_PORT);
      // all-ones and all-zeros bytes as ignored characters
      append_byte(8'hff);
      add_text("9,8,7,6,5,4");
      append_byte(8'h00);
      send_line(MODE_PORT);
      // reply lines: ok with trailing junk, missing close, missing open, empty, bare comma
      add_text("227 Entering Passive Mode (192,168,1,2,19,137)."); send_line(MODE_PASV);
      add_text("227 (1,2,3,4,5,6");              send_line(MODE_PASV);
      add_text("1,2,3,4,5,6)");                  send_line(MODE_PASV);
      add_text("()");                            send_line(MODE_PASV);
      add_text("(,)");                           send_line(MODE_PASV);
      // stray close before the open, bytes after the close ignored
      add_text(")x(1,2,3,4,5,6)(9,9");           send_line(MODE_PASV);
      add_text("(1,2,3,4,5,6,7,8)");             send_line(MODE_PASV);

      // random lines: mostly well-formed with random content, the rest broken or noise
      line_no = 0;
      while (bytes_sent < BYTE_BUDGET || port_lines + pasv_lines < MIN_LINES) begin
         if (bytes_sent >= BYTE_BUDGET * 4 / 5) begin
            // closing stretch runs with no idling on either side
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else begin
            if ($urandom_range(0, 3) == 0)
               tx_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
            if ($urandom_range(0, 3) == 0)
               rx_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
         end
         // one long result-side hold while words keep coming with no gaps
         if (line_no == 8) hold_request = 1'b1;
         if (hold_request) tx_idle_pct = 0;

         kind = $urandom_range(0, 99);
         op   = 1'($urandom_range(0, 1));
         if (kind < 35) begin
            op = MODE_PORT;
            add_numbers(6);
         end else if (kind < 70) begin
            op = MODE_PASV;
            build_pasv(6, 1'b1, 1'b1);
         end else if (kind < 80) begin
            // wrong number count, either mode
            n = $urandom_range(0, 7);
            if (n == 6) n = 8;
            if (op == MODE_PORT) add_numbers(n);
            else build_pasv(n, 1'b1, 1'b1);
         end else if (kind < 88) begin
            op = MODE_PASV;
            case ($urandom_range(0, 2))
               0: build_pasv(6, 1'b0, 1'b1);
               1: build_pasv(6, 1'b1, 1'b0);
               default: build_pasv(0, 1'b1, 1'b1);
            endcase
         end else begin
            repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
         end
         send_line(op);
         line_no++;
      end

      req_if.valid     = 1'b0;
      req_if.last_byte = 1'b0;

      // drain: every expected result word must show up, then a short settle
      wait (waiting == 0);
      repeat (10) @(posedge clock);

      $display("covered %0d lines (%0d PORT, %0d reply) in %0d byte words, %0d results checked",
               port_lines + pasv_lines, port_lines, pasv_lines, bytes_sent, results_seen);
      $display("long result-side hold-off %s",
               hold_done ? "applied with the input backed up" : "not reached");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
